### hw/rtl/pdwa_pkg.sv
`timescale 1ns / 1ps

package pdwa_pkg;

   // input item kinds
   localparam logic MODE_TICK   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_PERIOD = 2'd1;

   localparam int THRESHOLD_W = 12;
   localparam int PERIOD_W    = 16;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 12'd2048;
   localparam logic [PERIOD_W-1:0]    PERIOD_RESET    = 16'd10;

   // fixed point and field widths
   localparam int Q_FRAC = 16;
   localparam int Q_W    = 32;
   localparam int VE_W   = 8;
   localparam int RUN_W  = 20;
   localparam int MS_PER_SECOND = 1000;

   typedef struct packed {
      logic                   mode;
      logic [THRESHOLD_W-1:0] sample_value;
   } req_type;

   typedef struct packed {
      logic             recorded;
      logic [Q_W-1:0]   mean_seconds_q16;
      logic [Q_W-1:0]   rate_per_second_q16;
      logic [VE_W-1:0]  valid_entries;
      logic [RUN_W-1:0] running_ticks;
   } rsp_type;

endpackage

### hw/rtl/pulse_duration_window_averager.sv
`timescale 1ns / 1ps
// a tick or non-recording request passes the queue slot, then the response register
// a recording request is answered after the shared bit-serial divider (32 quotient bits,
//   one a cycle) runs for mean then rate; sooner on saturation or with no nonzero entries
// throughput: one request a cycle while nothing is recorded and rsp_ready is high;
//   a recording request holds the back end; the 2-entry queue takes requests until full
// reset: synchronous, clears window, counter, mean and rate and loads register defaults

module pulse_duration_window_averager #(
   parameter int SAMPLES    = 8,
   parameter int COUNT_BITS = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  pdwa_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output pdwa_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [pdwa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pdwa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pdwa_pkg::*;

   localparam int ENTRY_W = COUNT_BITS + 1;

   logic [THRESHOLD_W-1:0] threshold_ff;
   logic [PERIOD_W-1:0]    period_ff;
   logic                   fq_valid, fq_ready;
   logic [ENTRY_W-1:0]     fq_data;
   logic                   bq_valid, bq_ready;
   logic [ENTRY_W-1:0]     bq_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         period_ff    <= PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD:   threshold_ff <= csr_wdata[THRESHOLD_W-1:0];
            CSR_TICK_PERIOD: period_ff    <= csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   pdwa_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .threshold (threshold_ff),
      .q_valid   (fq_valid),
      .q_ready   (fq_ready),
      .q_data    (fq_data)
   );

   pdwa_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (bq_valid),
      .out_ready (bq_ready),
      .out_data  (bq_data)
   );

   pdwa_back #(
      .SAMPLES    (SAMPLES),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (bq_valid),
      .q_ready        (bq_ready),
      .q_data         (bq_data),
      .tick_period_ms (period_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

endmodule

### hw/rtl/pdwa_front.sv
`timescale 1ns / 1ps

module pdwa_front #(
   parameter int COUNT_BITS = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  pdwa_pkg::req_type                req_data,
   input  logic [pdwa_pkg::THRESHOLD_W-1:0] threshold,
   output logic                             q_valid,
   input  logic                             q_ready,
   output logic [COUNT_BITS:0]              q_data
);
   import pdwa_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  idle_ff, idle_in;
   logic                  accept;
   logic                  record;

   assign req_ready = q_ready;
   assign accept    = req_valid && q_ready;

   always_comb begin
      count_in = count_ff;
      idle_in  = idle_ff;
      record   = 1'b0;
      if (accept) begin
         if (req_data.mode == MODE_TICK) begin
            if (!idle_ff && count_ff != COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
         end else if (req_data.sample_value > threshold) begin
            idle_in = 1'b0;
         end else if (req_data.sample_value < threshold) begin
            // end of an active spell hands the finished count to the back end
            if (!idle_ff) begin
               record   = 1'b1;
               count_in = '0;
            end
            idle_in = 1'b1;
         end
      end
   end

   assign q_valid = req_valid;
   assign q_data  = {record, record ? count_ff : count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idle_ff  <= 1'b1;
      end else begin
         count_ff <= count_in;
         idle_ff  <= idle_in;
      end
   end

endmodule

### hw/rtl/pdwa_queue.sv
`timescale 1ns / 1ps

module pdwa_queue #(
   parameter int WIDTH = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wptr_ff, rptr_ff;
   logic [1:0]       fill_ff;
   logic             push, pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_data  = slot_ff[rptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (pop) begin
            rptr_ff <= ~rptr_ff;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

endmodule

### hw/rtl/pdwa_div.sv
`timescale 1ns / 1ps

// quotient = floor(num * 2^16 / den), saturated to all ones, one bit a cycle
module pdwa_div #(
   parameter int DIV_W = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIV_W-1:0]         num,
   input  logic [DIV_W-1:0]         den,
   output logic                     done,
   output logic [pdwa_pkg::Q_W-1:0] quot
);
   import pdwa_pkg::*;

   localparam int STEP_W = $clog2(Q_W);

   typedef enum logic {
      D_IDLE,
      D_RUN
   } div_state_type;

   div_state_type      state_ff;
   logic [DIV_W-1:0]   rem_ff;
   logic [DIV_W-1:0]   den_ff;
   logic [Q_W-1:0]     low_ff;
   logic [Q_W-1:0]     quot_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               done_ff;
   logic               overflow;
   logic [DIV_W:0]     trial;
   logic               fits;

   // the quotient does not fit in 32 bits when num >= den * 2^16 (also den of zero)
   assign overflow = {Q_FRAC'(0), num} >= {den, Q_FRAC'(0)};
   assign trial    = {rem_ff, low_ff[Q_W-1]};
   assign fits     = trial >= {1'b0, den_ff};
   assign done     = done_ff;
   assign quot     = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            D_IDLE: begin
               done_ff <= start && overflow;
               if (start) begin
                  if (overflow) begin
                     quot_ff <= '1;
                  end else begin
                     rem_ff   <= DIV_W'(num >> Q_FRAC);
                     low_ff   <= {num[Q_FRAC-1:0], Q_FRAC'(0)};
                     den_ff   <= den;
                     quot_ff  <= '0;
                     step_ff  <= '0;
                     state_ff <= D_RUN;
                  end
               end
            end
            D_RUN: begin
               rem_ff  <= fits ? DIV_W'(trial - {1'b0, den_ff}) : DIV_W'(trial);
               low_ff  <= {low_ff[Q_W-2:0], 1'b0};
               quot_ff <= {quot_ff[Q_W-2:0], fits};
               step_ff <= step_ff + 1'b1;
               done_ff <= (step_ff == STEP_W'(Q_W - 1));
               if (step_ff == STEP_W'(Q_W - 1)) begin
                  state_ff <= D_IDLE;
               end
            end
            default: begin
               done_ff  <= 1'b0;
               state_ff <= D_IDLE;
            end
         endcase
      end
   end

endmodule

### hw/rtl/pdwa_back.sv
`timescale 1ns / 1ps

module pdwa_back #(
   parameter int SAMPLES    = 8,
   parameter int COUNT_BITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  logic [COUNT_BITS:0]           q_data,
   input  logic [pdwa_pkg::PERIOD_W-1:0] tick_period_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pdwa_pkg::rsp_type             rsp_data
);
   import pdwa_pkg::*;

   localparam int CNT_W  = $clog2(SAMPLES + 1);
   localparam int SUM_W  = COUNT_BITS + CNT_W;
   localparam int PROD_W = SUM_W + PERIOD_W;
   localparam int VK_W   = CNT_W + 10;
   localparam int DIV_W  = (PROD_W > VK_W) ? PROD_W : VK_W;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_MEAN,
      B_MEAN_WAIT,
      B_RATE,
      B_RATE_WAIT,
      B_OUT
   } back_state_type;

   back_state_type        state_ff, state_in;
   logic [COUNT_BITS-1:0] win_ff [SAMPLES];
   logic [COUNT_BITS-1:0] win_in [SAMPLES];
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [VK_W-1:0]       vk_ff, vk_in;
   logic [Q_W-1:0]        mean_ff, mean_in;
   logic [Q_W-1:0]        rate_ff, rate_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  rec;
   logic [COUNT_BITS-1:0] dur;
   logic                  out_free;
   logic [VE_W+CNT_W-1:0] cnt_wide;
   logic [RUN_W+COUNT_BITS-1:0] run_wide;
   logic                  div_start;
   logic [DIV_W-1:0]      div_num, div_den;
   logic                  div_done;
   logic [Q_W-1:0]        div_quot;

   assign rec      = q_data[COUNT_BITS];
   assign dur      = q_data[COUNT_BITS-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cnt_wide = {VE_W'(0), cnt_ff};
   assign run_wide = {RUN_W'(0), dur};

   assign q_ready   = (state_ff == B_IDLE) && (rec || out_free);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign div_start = (state_ff == B_MEAN) || (state_ff == B_RATE);
   assign div_num   = (state_ff == B_RATE) ? DIV_W'(vk_ff) : DIV_W'(prod_ff);
   assign div_den   = (state_ff == B_RATE) ? DIV_W'(prod_ff) : DIV_W'(vk_ff);

   pdwa_div #(
      .DIV_W (DIV_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      vk_in        = vk_ff;
      mean_in      = mean_ff;
      rate_in      = rate_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid && q_ready) begin
               if (rec) begin
                  // shift in the new duration, keep sum and nonzero count running
                  for (int i = 0; i < SAMPLES - 1; i++) begin
                     win_in[i] = win_ff[i + 1];
                  end
                  win_in[SAMPLES-1] = dur;
                  sum_in = sum_ff + SUM_W'(dur) - SUM_W'(win_ff[0]);
                  cnt_in = cnt_ff + CNT_W'(dur != '0) - CNT_W'(win_ff[0] != '0);
                  state_in = B_MUL;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in.recorded            = 1'b0;
                  rsp_in.mean_seconds_q16    = mean_ff;
                  rsp_in.rate_per_second_q16 = rate_ff;
                  rsp_in.valid_entries       = cnt_wide[VE_W-1:0];
                  rsp_in.running_ticks       = run_wide[RUN_W-1:0];
               end
            end
         end
         B_MUL: begin
            prod_in = PROD_W'(sum_ff) * PROD_W'(tick_period_ms);
            vk_in   = VK_W'(cnt_ff) * VK_W'(MS_PER_SECOND);
            if (cnt_ff == '0) begin
               mean_in  = '0;
               rate_in  = '0;
               state_in = B_OUT;
            end else begin
               state_in = B_MEAN;
            end
         end
         B_MEAN: begin
            state_in = B_MEAN_WAIT;
         end
         B_MEAN_WAIT: begin
            if (div_done) begin
               mean_in  = div_quot;
               state_in = B_RATE;
            end
         end
         B_RATE: begin
            state_in = B_RATE_WAIT;
         end
         B_RATE_WAIT: begin
            if (div_done) begin
               rate_in  = div_quot;
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.recorded            = 1'b1;
               rsp_in.mean_seconds_q16    = mean_ff;
               rsp_in.rate_per_second_q16 = rate_ff;
               rsp_in.valid_entries       = cnt_wide[VE_W-1:0];
               rsp_in.running_ticks       = '0;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      vk_ff   <= vk_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= B_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         mean_ff      <= '0;
         rate_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SAMPLES; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         mean_ff      <= mean_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
